>>> rtl/sbs_pkg.sv
package sbs_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int BAND_W      = 5;
  localparam int LEVEL_W     = 17;
  localparam int HEIGHT_W    = 10;
  localparam int INTEN_W     = 8;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    level_t              level;
    logic [HEIGHT_W-1:0] height;
    logic [INTEN_W-1:0]  intensity;
  } calc_res_t;

  localparam level_t              LEVEL_ONE      = 17'h10000;
  localparam level_t              SNAP_LIMIT     = 17'd655;
  localparam level_t              FACTOR_RESET   = 17'd19661;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 10'd100;
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT     = 10'd2;
  localparam logic [HEIGHT_W-1:0] INTENSITY_SPAN = 10'd155;
  localparam logic [INTEN_W:0]    INTENSITY_BASE = 9'd100;
  localparam logic [INTEN_W:0]    INTENSITY_MAX  = 9'd255;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic REG_FACTOR = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

endpackage

>>> rtl/sbs_calc.sv
module sbs_calc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  sbs_pkg::level_t               cur,
  input  sbs_pkg::level_t               tgt,
  input  sbs_pkg::level_t               factor,
  input  logic [sbs_pkg::HEIGHT_W-1:0]  max_height,
  output logic                          done,
  output sbs_pkg::calc_res_t            res
);
  import sbs_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MIX   = 2'd1;
  localparam logic [1:0] PH_ROOT  = 2'd2;
  localparam logic [1:0] PH_SCALE = 2'd3;

  localparam logic [4:0] LEVEL_STEPS = 5'(LEVEL_W - 1);
  localparam logic [4:0] SCALE_STEPS = 5'(HEIGHT_W - 1);

  logic [1:0]          phase;
  logic [4:0]          cnt;
  level_t              cur_r;
  level_t              tgt_r;
  level_t              fsh;
  level_t              gsh;
  level_t              f_eff;
  level_t              g_eff;
  logic [17:0]         pp;
  logic [18:0]         mix_hi;
  logic [34:0]         acc;
  logic [34:0]         acc_next;
  level_t              mix_lvl;
  logic [33:0]         rad;
  logic [20:0]         rem;
  logic [20:0]         rem_sh;
  logic [20:0]         rem_next;
  logic [20:0]         trial;
  level_t              root;
  level_t              root_next;
  logic [HEIGHT_W-1:0] hsh;
  logic [HEIGHT_W-1:0] ksh;
  logic [17:0]         h_hi;
  logic [17:0]         k_hi;
  logic [26:0]         hacc;
  logic [26:0]         kacc;
  logic [26:0]         hacc_next;
  logic [26:0]         kacc_next;
  logic [HEIGHT_W-1:0] height_c;
  logic [INTEN_W:0]    inten_c;

  always_comb begin
    f_eff    = factor[LEVEL_W-1] ? LEVEL_ONE : factor;
    g_eff    = LEVEL_ONE - f_eff;
    pp       = (fsh[0] ? {1'b0, tgt_r} : 18'd0) + (gsh[0] ? {1'b0, cur_r} : 18'd0);
    mix_hi   = {1'b0, acc[34:17]} + {1'b0, pp};
    acc_next = {mix_hi, acc[16:1]};
    mix_lvl  = (acc_next[32:16] < SNAP_LIMIT) ? '0 : acc_next[32:16];

    rem_sh = {rem[18:0], rad[33:32]};
    trial  = {2'b00, root, 2'b01};
    if (rem_sh >= trial) begin
      rem_next  = rem_sh - trial;
      root_next = {root[15:0], 1'b1};
    end else begin
      rem_next  = rem_sh;
      root_next = {root[15:0], 1'b0};
    end

    h_hi      = {1'b0, hacc[26:10]} + (hsh[0] ? {1'b0, root} : 18'd0);
    k_hi      = {1'b0, kacc[26:10]} + (ksh[0] ? {1'b0, root} : 18'd0);
    hacc_next = {h_hi, hacc[9:1]};
    kacc_next = {k_hi, kacc[9:1]};
    height_c  = (hacc_next[25:16] < MIN_HEIGHT) ? MIN_HEIGHT : hacc_next[25:16];
    inten_c   = INTENSITY_BASE + {1'b0, kacc_next[23:16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (phase == PH_SCALE) && (cnt == 5'd0);
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_MIX;
            cnt   <= LEVEL_STEPS;
            acc   <= '0;
            fsh   <= f_eff;
            gsh   <= g_eff;
            cur_r <= cur;
            tgt_r <= tgt;
          end
        end
        PH_MIX: begin
          acc <= acc_next;
          fsh <= fsh >> 1;
          gsh <= gsh >> 1;
          if (cnt == 5'd0) begin
            phase     <= PH_ROOT;
            cnt       <= LEVEL_STEPS;
            res.level <= mix_lvl;
            rad       <= {1'b0, mix_lvl, 16'd0};
            rem       <= '0;
            root      <= '0;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        PH_ROOT: begin
          rem  <= rem_next;
          root <= root_next;
          rad  <= {rad[31:0], 2'b00};
          if (cnt == 5'd0) begin
            phase <= PH_SCALE;
            cnt   <= SCALE_STEPS;
            hsh   <= max_height;
            ksh   <= INTENSITY_SPAN;
            hacc  <= '0;
            kacc  <= '0;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        PH_SCALE: begin
          hacc <= hacc_next;
          kacc <= kacc_next;
          hsh  <= hsh >> 1;
          ksh  <= ksh >> 1;
          if (cnt == 5'd0) begin
            phase         <= PH_IDLE;
            res.height    <= height_c;
            res.intensity <= (inten_c > INTENSITY_MAX) ? INTENSITY_MAX[INTEN_W-1:0]
                                                       : inten_c[INTEN_W-1:0];
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/spectrum_bar_smoother.sv
// Per-band level smoother for a bar spectrum display (65536 = 1.0).
// Input channel (in_valid / in_stall): a load word (req_type 0) writes one
// band target, clamped to 0..1.0, in the cycle it is taken; a tick word
// (req_type 1) walks every band and gives one output word per band.
// Output channel (out_valid / out_stall): out_band, bar_height,
// color_intensity, last_band marks the final band of a tick.
// Config port: cfg_write with cfg_index 0 sets smoothing_factor, 1 sets
// max_bar_height; other indexes are dropped.
// Loads are taken whenever no tick is in progress. A tick handles the
// bands one at a time in the bit-serial arithmetic unit: smoothing
// multiply, square root, then height and intensity scaling, plus store
// read and handoff.
// in_stall is high while a tick is in progress. A stalled output word holds
// its value; the next band computes meanwhile and waits in the unit.
// Reset clears all targets and levels to zero and restores the default
// register values; no output word is pending after reset.
module spectrum_bar_smoother #(
  parameter int BAND_COUNT = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [sbs_pkg::BAND_W-1:0]    band_index,
  input  logic signed [17:0]            target_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbs_pkg::BAND_W-1:0]    out_band,
  output logic [sbs_pkg::HEIGHT_W-1:0]  bar_height,
  output logic [sbs_pkg::INTEN_W-1:0]   color_intensity,
  output logic                          last_band,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [sbs_pkg::LEVEL_W-1:0]   cfg_data
);
  import sbs_pkg::*;

  localparam int ACTIVE = (BAND_COUNT > STORE_DEPTH) ? STORE_DEPTH : BAND_COUNT;
  localparam int LAST   = ACTIVE - 1;
  localparam logic [BAND_W:0]   ACTIVE_N = ACTIVE[BAND_W:0];
  localparam logic [BAND_W-1:0] LAST_IDX = LAST[BAND_W-1:0];

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]          state;
  logic [BAND_W-1:0]   idx;
  level_t              smoothing_factor;
  logic [HEIGHT_W-1:0] max_bar_height;
  level_t              tmem [STORE_DEPTH];
  level_t              cmem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] tvalid;
  logic [STORE_DEPTH-1:0] cvalid;
  level_t              trd;
  level_t              crd;
  logic                trd_ok;
  logic                crd_ok;
  level_t              tgt_eff;
  level_t              cur_eff;
  level_t              load_lvl;
  logic                in_take;
  logic                load_we;
  logic                out_free;
  logic                emit;
  logic                calc_start;
  logic                calc_done;
  calc_res_t           calc_res;

  assign in_stall   = (state != ST_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign load_we    = in_take && (req_type == REQ_LOAD) && ({1'b0, band_index} < ACTIVE_N);
  assign out_free   = !out_valid || !out_stall;
  assign emit       = (state == ST_EMIT) && out_free;
  assign calc_start = (state == ST_START);
  assign tgt_eff    = trd_ok ? trd : '0;
  assign cur_eff    = crd_ok ? crd : '0;

  always_comb begin
    if (target_level[17]) begin
      load_lvl = '0;
    end else if (target_level[16:0] > LEVEL_ONE) begin
      load_lvl = LEVEL_ONE;
    end else begin
      load_lvl = target_level[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_factor <= FACTOR_RESET;
      max_bar_height   <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FACTOR: smoothing_factor <= cfg_data;
        REG_HEIGHT: max_bar_height   <= cfg_data[HEIGHT_W-1:0];
        default:    smoothing_factor <= smoothing_factor;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      tmem[band_index] <= load_lvl;
    end
    trd <= tmem[idx];
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cmem[idx] <= calc_res.level;
    end
    crd <= cmem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= '0;
      cvalid <= '0;
      trd_ok <= 1'b0;
      crd_ok <= 1'b0;
    end else begin
      if (load_we) begin
        tvalid[band_index] <= 1'b1;
      end
      if (emit) begin
        cvalid[idx] <= 1'b1;
      end
      trd_ok <= tvalid[idx];
      crd_ok <= cvalid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
      case (state)
        ST_IDLE: begin
          if (in_take && (req_type == REQ_TICK)) begin
            idx   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ:  state <= ST_START;
        ST_START: state <= ST_CALC;
        ST_CALC: begin
          if (calc_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (idx == LAST_IDX) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_band        <= idx;
      bar_height      <= calc_res.height;
      color_intensity <= calc_res.intensity;
      last_band       <= (idx == LAST_IDX);
    end
  end

  sbs_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .start      (calc_start),
    .cur        (cur_eff),
    .tgt        (tgt_eff),
    .factor     (smoothing_factor),
    .max_height (max_bar_height),
    .done       (calc_done),
    .res        (calc_res)
  );

endmodule
